// ===== rtl/wlcl_pkg.sv =====
// shared types, constants and codes of the window/level colour lookup unit
package wlcl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int SAMPLE_W = 24;
    localparam int SCALE_W  = 32;
    localparam int COLOUR_W = 32;
    localparam int SLOT_W   = 8;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int FRAC_W   = 24;
    localparam int CFG_IW   = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_RANGE_LOW    = 3'd0,
        REG_RANGE_HIGH   = 3'd1,
        REG_INDEX_SCALE  = 3'd2,
        REG_BELOW_COLOUR = 3'd3,
        REG_ABOVE_COLOUR = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IN_WINDOW = 2'd0,
        ST_BELOW     = 2'd1,
        ST_ABOVE     = 2'd2,
        ST_LOADED    = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] range_low;
        logic signed [SAMPLE_W-1:0] range_high;
        logic [SCALE_W-1:0]         index_scale;
        logic [COLOUR_W-1:0]        below_colour;
        logic [COLOUR_W-1:0]        above_colour;
    } cfg_t;

    // load enables of the index datapath stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } pipe_adv_t;

endpackage

// ===== rtl/wlcl_cfg_regs.sv =====
// configuration register bank of the window/level colour lookup unit
module wlcl_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [wlcl_pkg::CFG_IW-1:0] cfg_wr_index,
    input  logic [31:0]                 cfg_wr_data,
    output wlcl_pkg::cfg_t              cfg
);
    import wlcl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_RANGE_LOW:    cfg_next.range_low    = cfg_wr_data[SAMPLE_W-1:0];
                REG_RANGE_HIGH:   cfg_next.range_high   = cfg_wr_data[SAMPLE_W-1:0];
                REG_INDEX_SCALE:  cfg_next.index_scale  = cfg_wr_data[SCALE_W-1:0];
                REG_BELOW_COLOUR: cfg_next.below_colour = cfg_wr_data[COLOUR_W-1:0];
                REG_ABOVE_COLOUR: cfg_next.above_colour = cfg_wr_data[COLOUR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_low    <= '0;
            cfg_reg.range_high   <= 24'sh7FFFFF;
            cfg_reg.index_scale  <= 32'h0100_0000;
            cfg_reg.below_colour <= '0;
            cfg_reg.above_colour <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/wlcl_index_pipe.sv =====
// three-stage table index datapath: offset, multiply, round and cap
module wlcl_index_pipe (
    input  logic                                 aclk,
    input  wlcl_pkg::pipe_adv_t                  adv,
    input  logic signed [wlcl_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [wlcl_pkg::SAMPLE_W-1:0] range_low,
    input  logic [wlcl_pkg::SCALE_W-1:0]         index_scale,
    output logic [wlcl_pkg::TABLE_AW-1:0]        table_index
);
    import wlcl_pkg::*;

    localparam int RND_W = PROD_W + 1;
    localparam int IDX_W = RND_W - FRAC_W;

    logic [SAMPLE_W-1:0]  diff_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TABLE_AW-1:0]  index_reg;

    logic signed [SAMPLE_W:0] diff_full;
    logic [RND_W-1:0]         rounded;
    logic [IDX_W-1:0]         raw_index;
    logic [TABLE_AW-1:0]      index_next;

    // only meaningful inside the window, where the offset fits 24 bits unsigned
    assign diff_full = {sample[SAMPLE_W-1], sample} - {range_low[SAMPLE_W-1], range_low};

    assign rounded   = {1'b0, prod_reg} + (RND_W'(1) << (FRAC_W - 1));
    assign raw_index = rounded[RND_W-1:FRAC_W];

    always_comb begin
        if (raw_index > IDX_W'(TABLE_DEPTH - 1)) begin
            index_next = TABLE_AW'(TABLE_DEPTH - 1);
        end else begin
            index_next = raw_index[TABLE_AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            diff_reg <= diff_full[SAMPLE_W-1:0];
        end
        if (adv.s3) begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(index_scale);
        end
        if (adv.s4) begin
            index_reg <= index_next;
        end
    end

    assign table_index = index_reg;

endmodule

// ===== rtl/wlcl_table_ram.sv =====
// single-port colour table memory with registered read data
module wlcl_table_ram (
    input  logic                          aclk,
    input  logic                          en,
    input  logic                          we,
    input  logic [wlcl_pkg::TABLE_AW-1:0] addr,
    input  logic [wlcl_pkg::COLOUR_W-1:0] wdata,
    output logic [wlcl_pkg::COLOUR_W-1:0] rdata
);
    import wlcl_pkg::*;

    logic [COLOUR_W-1:0] mem [TABLE_DEPTH];
    logic [COLOUR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/window_level_colour_lut_map_unit.sv =====
// top level of the window/level colour lookup unit
//
// channel   direction  payload
// s_axis    in         tdata: table_slot, table_word, sample; tuser: opcode
// m_axis    out        tdata: colour; tuser: status
// cfg_wr    in         register index and data, written on cfg_wr_en
//
// one item per clock sustained while m_axis_tready allows; an item is captured, classified,
// indexed and read from the table, and the result is registered before it is offered on m_axis
// the path holds the 24x32 multiplier stage and the registered table read
// each stage moves when the one after it is empty or moving, so bubbles close
// up while a result waits on m_axis_tready
// reset clears stage valids and config registers; the colour table is not cleared
module window_level_colour_lut_map_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [wlcl_pkg::CFG_IW-1:0] cfg_wr_index,
    input  logic [31:0]                 cfg_wr_data,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,  // table_slot, table_word, sample
    input  logic                        s_axis_tuser,  // opcode
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // colour
    output logic [1:0]                  m_axis_tuser   // status
);
    import wlcl_pkg::*;

    cfg_t cfg;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;

    // ready chain, back to front
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic mv1, mv2, mv3, mv4, mv5;

    // stage 1: captured item
    opcode_t                    s1_op_reg;
    logic [SLOT_W-1:0]          s1_slot_reg;
    logic [COLOUR_W-1:0]        s1_word_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;

    // stages 2 to 5: status plus a shared data word
    // (table word for loads, the out-of-window colour for below/above)
    status_t             s2_status_reg, s3_status_reg, s4_status_reg, s5_status_reg;
    logic [COLOUR_W-1:0] s2_data_reg, s3_data_reg, s4_data_reg, s5_data_reg;
    logic [SLOT_W-1:0]   s2_slot_reg, s3_slot_reg, s4_slot_reg;

    status_t             s2_status_next;
    logic [COLOUR_W-1:0] s2_data_next;

    pipe_adv_t           adv;
    logic [TABLE_AW-1:0] table_index;

    // table access
    logic [15:0]          slot_wide;
    logic                 slot_ok;
    logic                 ram_en;
    logic                 ram_we;
    logic [TABLE_AW-1:0]  ram_addr;
    logic [COLOUR_W-1:0]  ram_rdata;

    wlcl_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // handshake
    assign rdy5 = !v5_reg || m_axis_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign mv1 = s_axis_tvalid && rdy1;
    assign mv2 = v1_reg && rdy2;
    assign mv3 = v2_reg && rdy3;
    assign mv4 = v3_reg && rdy4;
    assign mv5 = v4_reg && rdy5;

    assign v1_next = mv1 || (v1_reg && !mv2);
    assign v2_next = mv2 || (v2_reg && !mv3);
    assign v3_next = mv3 || (v3_reg && !mv4);
    assign v4_next = mv4 || (v4_reg && !mv5);
    assign v5_next = mv5 || (v5_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // window classification; load items bypass it
    always_comb begin
        if (s1_op_reg == OP_LOAD) begin
            s2_status_next = ST_LOADED;
            s2_data_next   = s1_word_reg;
        end else if (s1_sample_reg < cfg.range_low) begin
            s2_status_next = ST_BELOW;
            s2_data_next   = cfg.below_colour;
        end else if (s1_sample_reg > cfg.range_high) begin
            s2_status_next = ST_ABOVE;
            s2_data_next   = cfg.above_colour;
        end else begin
            s2_status_next = ST_IN_WINDOW;
            s2_data_next   = '0;
        end
    end

    // payload registers move with their stage
    always_ff @(posedge aclk) begin
        if (mv1) begin
            s1_op_reg     <= opcode_t'(s_axis_tuser);
            s1_slot_reg   <= s_axis_tdata[7:0];
            s1_word_reg   <= s_axis_tdata[39:8];
            s1_sample_reg <= s_axis_tdata[63:40];
        end
        if (mv2) begin
            s2_status_reg <= s2_status_next;
            s2_data_reg   <= s2_data_next;
            s2_slot_reg   <= s1_slot_reg;
        end
        if (mv3) begin
            s3_status_reg <= s2_status_reg;
            s3_data_reg   <= s2_data_reg;
            s3_slot_reg   <= s2_slot_reg;
        end
        if (mv4) begin
            s4_status_reg <= s3_status_reg;
            s4_data_reg   <= s3_data_reg;
            s4_slot_reg   <= s3_slot_reg;
        end
        if (mv5) begin
            s5_status_reg <= s4_status_reg;
            s5_data_reg   <= s4_data_reg;
        end
    end

    // index arithmetic runs alongside stages 2 to 4
    assign adv.s2 = mv2;
    assign adv.s3 = mv3;
    assign adv.s4 = mv4;

    wlcl_index_pipe u_index (
        .aclk        (aclk),
        .adv         (adv),
        .sample      (s1_sample_reg),
        .range_low   (cfg.range_low),
        .index_scale (cfg.index_scale),
        .table_index (table_index)
    );

    // one table access per load or in-window map as it enters the output stage; items
    // stay in order, so a map always sees every earlier load
    assign slot_wide = 16'(s4_slot_reg);
    assign slot_ok   = slot_wide < 16'(TABLE_DEPTH);
    assign ram_we    = (s4_status_reg == ST_LOADED) && slot_ok;
    assign ram_en    = mv5 && (ram_we || (s4_status_reg == ST_IN_WINDOW));
    assign ram_addr  = (s4_status_reg == ST_LOADED) ? slot_wide[TABLE_AW-1:0] : table_index;

    wlcl_table_ram u_table (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s4_data_reg),
        .rdata (ram_rdata)
    );

    // result selection; read data holds while the item waits
    always_comb begin
        case (s5_status_reg)
            ST_IN_WINDOW: m_axis_tdata = ram_rdata;
            ST_LOADED:    m_axis_tdata = '0;
            default:      m_axis_tdata = s5_data_reg;
        endcase
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tuser  = s5_status_reg;
    assign s_axis_tready = rdy1;

endmodule
